// ===== design/key_events_to_hid_report_assert.svh =====
// Assertion macros for the key-event-to-report datapath.
`ifndef KEY_EVENTS_TO_HID_REPORT_ASSERT_SVH
`define KEY_EVENTS_TO_HID_REPORT_ASSERT_SVH

// Checked at every rising edge while reset is released.
`define KEHR_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define KEHR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/kehr_pkg.sv =====
// Shared constants, codes and controller/datapath interface types.
package kehr_pkg;

    localparam int SCAN_FIRST     = 4;
    localparam int SCAN_END       = 224;
    localparam int ROLLOVER_SLOTS = 6;
    localparam int NUM_SLOTS      = 6;

    localparam int ROW_BITS  = 8;
    localparam int ROWS      = 256 / ROW_BITS;
    localparam int ROW_W     = $clog2(ROWS);
    localparam int REPORT_W  = 8 * (1 + NUM_SLOTS);

    localparam logic [7:0] CODE_ROLLOVER = 8'h01;
    localparam logic [7:0] CODE_CAPS     = 8'h39;
    localparam logic [7:0] CODE_SCROLL   = 8'h47;
    localparam logic [7:0] CODE_PAUSE    = 8'h48;
    localparam logic [7:0] CODE_NUM      = 8'h53;
    localparam logic [7:0] CODE_MOD_BASE = 8'hE0;

    localparam logic [2:0] LED_SCROLL = 3'b001;
    localparam logic [2:0] LED_NUM    = 3'b010;
    localparam logic [2:0] LED_CAPS   = 3'b100;

    localparam logic [7:0]       SCAN_FIRST_CODE = 8'(SCAN_FIRST);
    localparam logic [7:0]       SCAN_LAST_CODE  = 8'(SCAN_END - 1);
    localparam logic [2:0]       ROLL_LIM        = 3'(ROLLOVER_SLOTS);
    localparam logic [ROW_W-1:0] MOD_ROW         = CODE_MOD_BASE[7:3];
    localparam logic [ROW_W-1:0] PAUSE_ROW       = CODE_PAUSE[7:3];
    localparam logic [2:0]       PAUSE_BIT       = CODE_PAUSE[2:0];

    // Row selects for the bitmap read port.
    localparam logic [1:0] ROW_SEL_EVENT = 2'd0;
    localparam logic [1:0] ROW_SEL_MOD   = 2'd1;
    localparam logic [1:0] ROW_SEL_SCAN  = 2'd2;
    localparam logic [1:0] ROW_SEL_PAUSE = 2'd3;

    typedef struct packed {
        logic       accept;
        logic       rd_en;
        logic [1:0] rd_sel;
        logic       wr_en;
        logic       wr_pause;
        logic       led_upd;
        logic       led_set;
        logic       begin_build;
        logic       mod_cap;
        logic       scan_step;
        logic       finish;
    } kehr_cmd_t;

    typedef struct packed {
        logic batch;
        logic scan_last;
        logic row_end;
        logic ovf_now;
        logic pause_hit;
        logic out_busy;
    } kehr_sts_t;

endpackage

// ===== design/kehr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module kehr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/kehr_ctrl.sv =====
// Sequencer for key events, LED updates and the bitmap scan.
module kehr_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    input  logic              s_tuser,
    output logic              s_tready,
    input  kehr_pkg::kehr_sts_t sts,
    output kehr_pkg::kehr_cmd_t cmd
);

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_EV_RD   = 4'd1;
    localparam logic [3:0] ST_EV_WR   = 4'd2;
    localparam logic [3:0] ST_LED     = 4'd3;
    localparam logic [3:0] ST_MOD_RD  = 4'd4;
    localparam logic [3:0] ST_MOD_CAP = 4'd5;
    localparam logic [3:0] ST_SC_RD   = 4'd6;
    localparam logic [3:0] ST_SC_BIT  = 4'd7;
    localparam logic [3:0] ST_PZ_RD   = 4'd8;
    localparam logic [3:0] ST_PZ_WR   = 4'd9;
    localparam logic [3:0] ST_FINISH  = 4'd10;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
                if (s_tvalid) begin
                    state_next = s_tuser ? ST_LED : ST_EV_RD;
                end
            end
            ST_EV_RD: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = kehr_pkg::ROW_SEL_EVENT;
                state_next = ST_EV_WR;
            end
            ST_EV_WR: begin
                cmd.wr_en   = 1'b1;
                cmd.led_upd = 1'b1;
                state_next  = sts.batch ? ST_MOD_RD : ST_FINISH;
            end
            ST_LED: begin
                cmd.led_set = 1'b1;
                state_next  = ST_FINISH;
            end
            ST_MOD_RD: begin
                cmd.rd_en       = 1'b1;
                cmd.rd_sel      = kehr_pkg::ROW_SEL_MOD;
                cmd.begin_build = 1'b1;
                state_next      = ST_MOD_CAP;
            end
            ST_MOD_CAP: begin
                cmd.mod_cap = 1'b1;
                state_next  = ST_SC_RD;
            end
            ST_SC_RD: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = kehr_pkg::ROW_SEL_SCAN;
                state_next = ST_SC_BIT;
            end
            ST_SC_BIT: begin
                cmd.scan_step = 1'b1;
                if (sts.ovf_now || sts.scan_last) begin
                    state_next = sts.pause_hit ? ST_PZ_RD : ST_FINISH;
                end else if (sts.row_end) begin
                    state_next = ST_SC_RD;
                end
            end
            ST_PZ_RD: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = kehr_pkg::ROW_SEL_PAUSE;
                state_next = ST_PZ_WR;
            end
            ST_PZ_WR: begin
                cmd.wr_en    = 1'b1;
                cmd.wr_pause = 1'b1;
                state_next   = ST_FINISH;
            end
            ST_FINISH: begin
                if (!sts.out_busy) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== design/kehr_datapath.sv =====
// Key bitmap, LED state, report builder and output register.
`include "key_events_to_hid_report_assert.svh"

module kehr_datapath (
    input  logic                aclk,
    input  logic                aresetn,
    input  kehr_pkg::kehr_cmd_t cmd,
    output kehr_pkg::kehr_sts_t sts,
    input  logic [15:0]         s_tdata,
    input  logic                s_tuser,
    input  logic                s_tlast,
    input  logic                m_tready,
    output logic                m_tvalid,
    output logic [63:0]         m_tdata,
    output logic [1:0]          m_tuser
);

    localparam int RW = kehr_pkg::ROW_W;

    // Latched input item.
    logic [7:0] code_reg;
    logic       press_reg;
    logic       func_reg;
    logic       batch_reg;
    logic [2:0] host_reg;

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            code_reg  <= s_tdata[7:0];
            press_reg <= s_tdata[8];
            host_reg  <= s_tdata[11:9];
            func_reg  <= s_tuser;
            batch_reg <= s_tlast;
        end
    end

    // Bitmap RAM, one row of eight keys per entry, with a valid bit per row.
    logic [RW-1:0]             rd_row;
    logic [RW-1:0]             wr_row;
    logic [2:0]                wr_bit;
    logic [7:0]                wr_mask;
    logic [7:0]                wr_data;
    logic [7:0]                ram_q;
    logic [7:0]                row_word;
    logic [kehr_pkg::ROWS-1:0] row_valid_reg;
    logic                      valid_q_reg;
    logic [7:0]                scan_code_reg;

    always_comb begin
        case (cmd.rd_sel)
            kehr_pkg::ROW_SEL_EVENT: rd_row = code_reg[7:3];
            kehr_pkg::ROW_SEL_MOD:   rd_row = kehr_pkg::MOD_ROW;
            kehr_pkg::ROW_SEL_SCAN:  rd_row = scan_code_reg[7:3];
            kehr_pkg::ROW_SEL_PAUSE: rd_row = kehr_pkg::PAUSE_ROW;
            default:                 rd_row = code_reg[7:3];
        endcase
    end

    assign row_word = valid_q_reg ? ram_q : 8'h00;
    assign wr_row   = cmd.wr_pause ? kehr_pkg::PAUSE_ROW : code_reg[7:3];
    assign wr_bit   = cmd.wr_pause ? kehr_pkg::PAUSE_BIT : code_reg[2:0];
    assign wr_mask  = 8'(8'h01 << wr_bit);
    assign wr_data  = (press_reg && !cmd.wr_pause) ? (row_word | wr_mask)
                                                   : (row_word & ~wr_mask);

    kehr_ram #(
        .WIDTH(8),
        .DEPTH(kehr_pkg::ROWS)
    ) u_bitmap (
        .aclk   (aclk),
        .wr_en  (cmd.wr_en),
        .wr_addr(wr_row),
        .wr_data(wr_data),
        .rd_en  (cmd.rd_en),
        .rd_addr(rd_row),
        .rd_data(ram_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_valid_reg <= '0;
        end else if (cmd.wr_en) begin
            row_valid_reg[wr_row] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.rd_en) begin
            valid_q_reg <= row_valid_reg[rd_row];
        end
    end

    // Lock LEDs in PS/2 order: bit0 scroll, bit1 num, bit2 caps.
    logic [2:0] leds_reg;
    logic       led_chg_reg;
    logic [2:0] lock_mask;

    always_comb begin
        lock_mask = 3'b000;
        if (!press_reg) begin
            case (code_reg)
                kehr_pkg::CODE_SCROLL: lock_mask = kehr_pkg::LED_SCROLL;
                kehr_pkg::CODE_NUM:    lock_mask = kehr_pkg::LED_NUM;
                kehr_pkg::CODE_CAPS:   lock_mask = kehr_pkg::LED_CAPS;
                default:               lock_mask = 3'b000;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            leds_reg    <= 3'b000;
            led_chg_reg <= 1'b0;
        end else if (cmd.accept) begin
            led_chg_reg <= 1'b0;
        end else if (cmd.led_set) begin
            // Host order is num, caps, scroll from bit 0 up.
            leds_reg    <= {host_reg[1], host_reg[0], host_reg[2]};
            led_chg_reg <= 1'b1;
        end else if (cmd.led_upd && (lock_mask != 3'b000)) begin
            leds_reg    <= leds_reg ^ lock_mask;
            led_chg_reg <= 1'b1;
        end
    end

    // Scan: one key code per cycle within a row, with a bitmap read before each row, filling slots in ascending order.
    logic [7:0] mod_reg;
    logic [7:0] slot_reg [kehr_pkg::NUM_SLOTS];
    logic [2:0] pos_reg;
    logic       ovf_reg;
    logic       pause_reg;
    logic       hit;
    logic       ovf_now;
    logic       place;
    logic       scan_last;

    assign hit       = row_word[scan_code_reg[2:0]];
    assign ovf_now   = hit && (pos_reg >= kehr_pkg::ROLL_LIM);
    assign place     = hit && !ovf_now;
    assign scan_last = (scan_code_reg == kehr_pkg::SCAN_LAST_CODE);

    always_ff @(posedge aclk) begin
        if (cmd.begin_build) begin
            for (int i = 0; i < kehr_pkg::NUM_SLOTS; i++) begin
                slot_reg[i] <= 8'h00;
            end
            scan_code_reg <= kehr_pkg::SCAN_FIRST_CODE;
        end else if (cmd.scan_step) begin
            if (place) begin
                slot_reg[pos_reg] <= scan_code_reg;
            end
            if (!(ovf_now || scan_last)) begin
                scan_code_reg <= scan_code_reg + 8'd1;
            end
        end
        if (cmd.mod_cap) begin
            mod_reg <= row_word;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= 3'd0;
            ovf_reg   <= 1'b0;
            pause_reg <= 1'b0;
        end else if (cmd.begin_build) begin
            pos_reg   <= 3'd0;
            ovf_reg   <= 1'b0;
            pause_reg <= 1'b0;
        end else if (cmd.scan_step) begin
            if (place) begin
                pos_reg <= pos_reg + 3'd1;
                if (scan_code_reg == kehr_pkg::CODE_PAUSE) begin
                    pause_reg <= 1'b1;
                end
            end
            if (ovf_now) begin
                ovf_reg <= 1'b1;
            end
        end
    end

    // Report assembly, change detection and output register.
    logic [kehr_pkg::REPORT_W-1:0] report;
    logic [kehr_pkg::REPORT_W-1:0] prev_reg;
    logic                          changed;
    logic                          m_tvalid_reg;
    logic [63:0]                   m_tdata_reg;
    logic [1:0]                    m_tuser_reg;

    always_comb begin
        report[7:0] = mod_reg;
        for (int i = 0; i < kehr_pkg::NUM_SLOTS; i++) begin
            report[8*(i+1) +: 8] = ovf_reg ? kehr_pkg::CODE_ROLLOVER : slot_reg[i];
        end
    end

    assign changed = !func_reg && batch_reg && (report != prev_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else if (cmd.finish) begin
            if (changed) begin
                prev_reg <= report;
            end
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            m_tdata_reg <= {5'b0, leds_reg, (changed ? report : '0)};
            m_tuser_reg <= {led_chg_reg, changed};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    assign sts.batch     = batch_reg;
    assign sts.scan_last = scan_last;
    assign sts.row_end   = (scan_code_reg[2:0] == 3'd7);
    assign sts.ovf_now   = ovf_now;
    assign sts.pause_hit = pause_reg || (place && (scan_code_reg == kehr_pkg::CODE_PAUSE));
    assign sts.out_busy  = m_tvalid_reg && !m_tready;

    // Every bitmap write is the second half of a read-modify-write.
    `KEHR_ASSERT(a_wr_after_rd, aclk, aresetn, cmd.wr_en |-> $past(cmd.rd_en), "write without read")
    `KEHR_ASSERT_ALWAYS(a_no_rd_wr, aclk, !(cmd.wr_en && cmd.rd_en), "bitmap read and write collide")
    `KEHR_ASSERT(a_pos_bound, aclk, aresetn, pos_reg <= kehr_pkg::ROLL_LIM, "slot index overrun")
    `KEHR_ASSERT(a_ovf_full, aclk, aresetn, ovf_reg |-> (pos_reg == kehr_pkg::ROLL_LIM), "rollover before slots full")

endmodule

// ===== design/key_events_to_hid_report.sv =====
// Top level: key events and host LED beats in, boot keyboard reports out.
//
// Input beats on the s_ channel carry either a key event (s_tuser = 0) or a
// host LED setting (s_tuser = 1). s_tlast marks the last key event of a
// batch; only such an event builds a boot report. Every input beat produces
// exactly one output beat on the m_ channel. m_tuser[0] says whether the
// beat carries a new report that differs from the last one given, and
// m_tuser[1] says whether the lock LED state was toggled or set.
// A key event without s_tlast goes through a bitmap read, a bitmap write and the
// finish step; an LED beat sets the LEDs and then finishes. A batch end also reads
// the modifier row, scans the bitmap and clears a placed Pause key: the
// pressed-key bitmap lives in a 32 x 8 RAM with a registered read, and the scan
// walks codes 4 through 223 one per cycle, with a row read before each row,
// stopping early on rollover; clearing Pause is a read and a write.
// The block works on one beat at a time; s_tready is high only while idle.
// A finished result sits in an output register, so the next beat is taken
// while it waits; if the receiver stalls, the following result waits until
// the register frees. Reset (aresetn low, synchronous) releases all keys,
// clears the last report and turns the LEDs off, with no clearing pass.
module key_events_to_hid_report (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // key_code[7:0], is_press[8], host_leds[11:9], zero
    input  logic        s_tuser,   // func
    input  logic        s_tlast,   // batch_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // modifiers[7:0], slot0..slot5[55:8], led_state[58:56], zero
    output logic [1:0]  m_tuser    // report_valid[0], leds_changed[1]
);

    // Commands from the sequencer and status back from the datapath.
    kehr_pkg::kehr_cmd_t cmd;
    kehr_pkg::kehr_sts_t sts;

    kehr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tuser (s_tuser),
        .s_tready(s_tready),
        .sts     (sts),
        .cmd     (cmd)
    );

    kehr_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .sts     (sts),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .s_tlast (s_tlast),
        .m_tready(m_tready),
        .m_tvalid(m_tvalid),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

endmodule

// ===== sim/kehr_report_checker.sv =====
// Checker for the key event to boot report block: predicts every result beat and compares it.
module kehr_report_checker
    import kehr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,   // key_code[7:0], is_press[8], host_leds[11:9], zero
    input  logic        s_tuser,   // func
    input  logic        s_tlast,   // batch_end
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [63:0] m_tdata,   // modifiers[7:0], slot0..slot5[55:8], led_state[58:56], zero
    input  logic [1:0]  m_tuser,   // report_valid[0], leds_changed[1]
    output int          mismatches,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic FUNC_HOST_LEDS = 1'b1;

    typedef struct packed {
        logic            new_report;
        logic [7:0]      mods;
        logic [5:0][7:0] slots;
        logic            leds_changed;
        logic [2:0]      leds;
    } hid_beat_t;

    // Shadow of the block state.
    bit              key_held [256];
    logic [7:0]      sent_mods;
    logic [5:0][7:0] sent_slots;
    logic [2:0]      lock_state;

    hid_beat_t       report_fifo [$];
    int              result_idx;

    initial mismatches = 0;

    task automatic log_mismatch(input string msg);
        $display("[%0t] result %0d: %s", $realtime, result_idx, msg);
        mismatches++;
    endtask

    task automatic compare_field(input string name, input int unsigned got,
                                 input int unsigned want);
        if (got != want)
            log_mismatch($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
    endtask

    // Applies one input beat to the shadow state and returns the result beat it causes.
    function automatic hid_beat_t predict_report(input logic func, input logic [7:0] code,
                                                 input logic press, input logic last,
                                                 input logic [2:0] host);
        hid_beat_t       res;
        logic [7:0]      mods;
        logic [5:0][7:0] slots;
        int              fill;
        logic            spill;
        res = '0;
        if (func == FUNC_HOST_LEDS) begin
            // Host order is num, caps, scroll; the local order is scroll, num, caps.
            lock_state = (host[0] ? LED_NUM : 3'b000) | (host[1] ? LED_CAPS : 3'b000)
                       | (host[2] ? LED_SCROLL : 3'b000);
            res.leds_changed = 1'b1;
        end else begin
            key_held[code] = press;
            if (!press) begin
                if (code == CODE_SCROLL) begin
                    lock_state ^= LED_SCROLL;
                    res.leds_changed = 1'b1;
                end else if (code == CODE_NUM) begin
                    lock_state ^= LED_NUM;
                    res.leds_changed = 1'b1;
                end else if (code == CODE_CAPS) begin
                    lock_state ^= LED_CAPS;
                    res.leds_changed = 1'b1;
                end
            end
            if (last) begin
                mods  = '0;
                slots = '0;
                fill  = 0;
                spill = 1'b0;
                for (int i = 0; i < 8; i++)
                    mods[i] = key_held[CODE_MOD_BASE + i];
                for (int c = SCAN_FIRST; c < SCAN_END && !spill; c++) begin
                    if (key_held[c]) begin
                        if (fill >= ROLLOVER_SLOTS) begin
                            spill = 1'b1;
                        end else begin
                            slots[fill] = 8'(c);
                            fill++;
                            // Pause is released as soon as it lands in a slot.
                            if (c == CODE_PAUSE)
                                key_held[c] = 1'b0;
                        end
                    end
                end
                if (spill)
                    for (int i = 0; i < NUM_SLOTS; i++)
                        slots[i] = CODE_ROLLOVER;
                if ({mods, slots} != {sent_mods, sent_slots}) begin
                    sent_mods      = mods;
                    sent_slots     = slots;
                    res.new_report = 1'b1;
                    res.mods       = mods;
                    res.slots      = slots;
                end
            end
        end
        res.leds = lock_state;
        return res;
    endfunction

    always @(posedge aclk) begin : watch_channels
        hid_beat_t want;
        if (!aresetn) begin
            foreach (key_held[i])
                key_held[i] = 1'b0;
            sent_mods  = '0;
            sent_slots = '0;
            lock_state = '0;
            result_idx = 0;
            report_fifo.delete();
        end else begin
            // A result beat never belongs to an input beat taken at the same edge,
            // so the output side is handled first.
            if (m_tvalid && m_tready) begin
                if (report_fifo.size() == 0) begin
                    log_mismatch($sformatf("result beat with nothing expected, data 0x%0h",
                                           m_tdata));
                end else begin
                    want = report_fifo.pop_front();
                    compare_field("report_valid", m_tuser[0], want.new_report);
                    compare_field("modifiers", m_tdata[7:0], want.mods);
                    for (int i = 0; i < NUM_SLOTS; i++)
                        compare_field($sformatf("slot%0d", i), m_tdata[8*i+8 +: 8],
                                      want.slots[i]);
                    compare_field("leds_changed", m_tuser[1], want.leds_changed);
                    compare_field("led_state", m_tdata[58:56], want.leds);
                    compare_field("padding", m_tdata[63:59], 0);
                end
                result_idx++;
            end
            if (s_tvalid && s_tready)
                report_fifo.push_back(predict_report(s_tuser, s_tdata[7:0], s_tdata[8],
                                                     s_tlast, s_tdata[11:9]));
        end
        pending <= report_fifo.size();
    end

endmodule

// ===== sim/tb_key_events_to_hid_report.sv =====
// Testbench top: drives key event and host LED beats into the block and gives the verdict.
module tb_key_events_to_hid_report;
    timeunit 1ns;
    timeprecision 1ps;

    import kehr_pkg::*;

    localparam logic FUNC_KEY_EVENT = 1'b0;
    localparam logic FUNC_HOST_LEDS = 1'b1;

    // Number of input beats after which the random part stops.
    localparam int ITEM_TARGET = 1850;
    // A batch end scans the whole bitmap; add the longest receiver stall and
    // sender gap to the scan time and take the sum many times over.
    localparam int STALL_LIMIT = 4000;
    // Quiet time after the last expected result, to catch stray beats.
    localparam int DRAIN_CYCLES = 300;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;   // key_code[7:0], is_press[8], host_leds[11:9], zero
    logic        s_tuser;   // func
    logic        s_tlast;   // batch_end
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;   // modifiers[7:0], slot0..slot5[55:8], led_state[58:56], zero
    logic [1:0]  m_tuser;   // report_valid[0], leds_changed[1]

    int          mismatches;
    int          pending;
    int          beats_sent;
    int          burst_left;
    int          idle_cycles;
    int          rx_mode;
    int          rx_left;

    // Keys the stimulus believes are held; used only to shape the random part
    // so that releases mostly hit keys that are down.
    logic [7:0]  held_keys [$];

    key_events_to_hid_report u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    kehr_report_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .mismatches (mismatches),
        .pending    (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Sends one beat and returns after it is accepted and any gap that follows. The sender
    // works in bursts: once a burst is used up, valid drops for a random gap.
    // A gap of zero leaves valid high, so it is never lowered and raised again
    // in the same step.
    task automatic send_beat(input logic func, input logic [7:0] code, input logic press,
                             input logic last, input logic [2:0] leds);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tlast  <= last;
        s_tdata  <= {4'b0000, leds, press, code};
        do @(posedge aclk); while (!s_tready);
        beats_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            // Now and then a long burst gives a stretch with no sender idling.
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 16);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    // Holds the sender off until every expected result beat has come back.
    // The checker updates its count with a nonblocking assignment, so reading
    // it after an edge is free of races.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
    endtask

    // The receiver switches between stall patterns of its own: always ready,
    // coin-flip ready, mostly ready, and a periodic pattern with long stalls.
    always @(posedge aclk) begin
        if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(20, 200);
        end else begin
            rx_left--;
        end
        case (rx_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            2:       m_tready <= ($urandom_range(0, 7) != 0);
            default: m_tready <= (rx_left % 16) < 4;
        endcase
    end

    // Watchdog: ends the run if neither channel moves a beat for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int         len;
        int         target;
        int         pick;
        int         idx;
        logic [7:0] code;
        logic       last;
        bit         held_off;

        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = FUNC_KEY_EVENT;
        s_tlast     = 1'b0;
        m_tready    = 1'b0;
        beats_sent  = 0;
        burst_left  = 0;
        idle_cycles = 0;
        rx_mode     = 0;
        rx_left     = 0;
        held_off    = 1'b0;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part. Host LED beats first: all on with every ignored field
        // set, all off, and caps alone to check the bit order remap.
        send_beat(FUNC_HOST_LEDS, 8'hFF, 1'b1, 1'b1, 3'b111);
        send_beat(FUNC_HOST_LEDS, 8'h00, 1'b0, 1'b0, 3'b000);
        send_beat(FUNC_HOST_LEDS, 8'hA5, 1'b1, 1'b0, 3'b010);
        // Lowest and highest modifier, first and last scanned code; host_leds
        // is set on a key event to show that it is ignored there.
        send_beat(FUNC_KEY_EVENT, CODE_MOD_BASE, 1'b1, 1'b0, 3'b111);
        send_beat(FUNC_KEY_EVENT, CODE_MOD_BASE + 8'd7, 1'b1, 1'b0, 3'b000);
        send_beat(FUNC_KEY_EVENT, SCAN_FIRST_CODE, 1'b1, 1'b0, 3'b000);
        send_beat(FUNC_KEY_EVENT, SCAN_LAST_CODE, 1'b1, 1'b1, 3'b000);
        // Same report again, then codes outside the scan range: no new report.
        send_beat(FUNC_KEY_EVENT, SCAN_FIRST_CODE, 1'b1, 1'b1, 3'b000);
        send_beat(FUNC_KEY_EVENT, 8'h00, 1'b1, 1'b1, 3'b000);
        send_beat(FUNC_KEY_EVENT, 8'hFF, 1'b1, 1'b1, 3'b000);
        // Pause shows up once and is then released by the block itself.
        send_beat(FUNC_KEY_EVENT, CODE_PAUSE, 1'b1, 1'b1, 3'b000);
        send_beat(FUNC_KEY_EVENT, 8'h00, 1'b0, 1'b1, 3'b000);
        // Fill all six slots, then one key more for the rollover report.
        send_beat(FUNC_KEY_EVENT, 8'h05, 1'b1, 1'b0, 3'b000);
        send_beat(FUNC_KEY_EVENT, 8'h06, 1'b1, 1'b0, 3'b000);
        send_beat(FUNC_KEY_EVENT, 8'h07, 1'b1, 1'b0, 3'b000);
        send_beat(FUNC_KEY_EVENT, 8'h08, 1'b1, 1'b1, 3'b000);
        send_beat(FUNC_KEY_EVENT, 8'h09, 1'b1, 1'b1, 3'b000);
        // Pause behind a rollover is never placed, so it stays held.
        send_beat(FUNC_KEY_EVENT, CODE_PAUSE, 1'b1, 1'b1, 3'b000);
        // Lock keys released without a press still toggle their LEDs.
        send_beat(FUNC_KEY_EVENT, CODE_CAPS, 1'b0, 1'b0, 3'b000);
        send_beat(FUNC_KEY_EVENT, CODE_NUM, 1'b0, 1'b0, 3'b000);
        send_beat(FUNC_KEY_EVENT, CODE_SCROLL, 1'b0, 1'b1, 3'b000);
        // Back to six keys: the held Pause lands in a slot and is cleared.
        send_beat(FUNC_KEY_EVENT, 8'h09, 1'b0, 1'b0, 3'b000);
        send_beat(FUNC_KEY_EVENT, 8'h05, 1'b0, 1'b1, 3'b000);
        send_beat(FUNC_KEY_EVENT, CODE_MOD_BASE, 1'b0, 1'b1, 3'b000);

        // Random part: batches of key events that end with a marked event, each
        // batch aiming at its own number of held keys so that empty, partly
        // full, full and rollover reports all occur. A few beats are noise:
        // host LED beats with random content and events on arbitrary codes.
        while (beats_sent < ITEM_TARGET) begin
            if (!held_off && beats_sent >= ITEM_TARGET / 2) begin
                wait_drained();
                held_off = 1'b1;
            end
            len    = $urandom_range(1, 6);
            target = $urandom_range(0, 9);
            for (int n = 0; n < len; n++) begin
                last = (n == len - 1);
                pick = $urandom_range(0, 99);
                if (pick < 6) begin
                    send_beat(FUNC_HOST_LEDS, 8'($urandom), 1'($urandom), 1'($urandom),
                              3'($urandom));
                end else if (pick < 12) begin
                    send_beat(FUNC_KEY_EVENT, 8'($urandom), 1'($urandom), last,
                              3'($urandom));
                end else if (held_keys.size() < target || held_keys.size() == 0) begin
                    case ($urandom_range(0, 9))
                        0:       code = CODE_MOD_BASE + 8'($urandom_range(0, 7));
                        1:       code = ($urandom_range(0, 1) == 0) ? CODE_CAPS :
                                        ($urandom_range(0, 1) == 0) ? CODE_NUM : CODE_SCROLL;
                        2:       code = CODE_PAUSE;
                        3:       code = 8'($urandom_range(0, 255));
                        default: code = 8'($urandom_range(SCAN_FIRST, SCAN_FIRST + 24));
                    endcase
                    held_keys.push_back(code);
                    send_beat(FUNC_KEY_EVENT, code, 1'b1, last, 3'($urandom));
                end else begin
                    idx  = $urandom_range(0, held_keys.size() - 1);
                    code = held_keys[idx];
                    held_keys.delete(idx);
                    send_beat(FUNC_KEY_EVENT, code, 1'b0, last, 3'($urandom));
                end
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
